// File: hw/rtl/descriptor_slot_allocator_core_assert.svh
// ----------------------------------------------------------------------------
// Descriptor slot allocator assertion macros
// Concurrent checks on the core's internal handshakes, clocked and reset-gated.
// ----------------------------------------------------------------------------
`ifndef DESCRIPTOR_SLOT_ALLOCATOR_CORE_ASSERT_SVH
`define DESCRIPTOR_SLOT_ALLOCATOR_CORE_ASSERT_SVH

// same-cycle implication
`define DSA_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("descriptor slot allocator check failed");

// next-cycle implication
`define DSA_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("descriptor slot allocator check failed");

`endif

// File: hw/rtl/dsa_pkg.sv
// ----------------------------------------------------------------------------
// Descriptor slot allocator package
// Field widths, codes and the payload and control types shared by the core.
// ----------------------------------------------------------------------------
package dsa_pkg;

   localparam int FUNC_W      = 2;
   localparam int SLOT_W      = 10;
   localparam int STATUS_W    = 2;
   localparam int ADDR_W      = 48;
   localparam int HSIZE_W     = 9;
   localparam int COUNT_W     = 11;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 48;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [COUNT_W-1:0] SLOT_COUNT_RESET  = 11'd1024;
   localparam logic [HSIZE_W-1:0] HANDLE_SIZE_RESET = 9'd32;

   // request function codes
   localparam logic [FUNC_W-1:0] FUNC_AUTO  = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_FIXED = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_FREE  = 2'd2;

   // response status codes
   localparam logic [STATUS_W-1:0] ST_OK           = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NO_FREE      = 2'd1;
   localparam logic [STATUS_W-1:0] ST_TAKEN        = 2'd2;
   localparam logic [STATUS_W-1:0] ST_OUT_OF_RANGE = 2'd3;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_SLOT_COUNT     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_HANDLE_SIZE    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CPU_START      = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SHADER_CPU     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_SHADER_GPU     = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_SHADER_PRESENT = 3'd5;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic [SLOT_W-1:0] search_base;
      logic [SLOT_W-1:0] slot_index;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [SLOT_W-1:0]   granted_slot;
      logic [ADDR_W-1:0]   cpu_handle;
      logic [ADDR_W-1:0]   shader_cpu_handle;
      logic [ADDR_W-1:0]   shader_gpu_handle;
   } rsp_type;

   typedef enum logic [1:0] {
      OP_AUTO,
      OP_FIXED,
      OP_FREE,
      OP_REJECT
   } op_type;

   // classified request handed from front to back
   typedef struct packed {
      op_type              op;
      logic [STATUS_W-1:0] status;
      logic [SLOT_W-1:0]   target;
   } cmd_type;

   typedef struct packed {
      logic [HSIZE_W-1:0] handle_size;
      logic [ADDR_W-1:0]  cpu_heap_start;
      logic [ADDR_W-1:0]  shader_cpu_heap_start;
      logic [ADDR_W-1:0]  shader_gpu_heap_start;
      logic               shader_heap_present;
   } cfg_type;

   typedef enum logic [2:0] {
      BK_CLEAR,
      BK_IDLE,
      BK_WALK,
      BK_READ,
      BK_CHECK,
      BK_MUL,
      BK_ADD,
      BK_OUT
   } back_state_type;

   typedef struct packed {
      logic clearing;
      logic idle;
   } back_stat_type;

endpackage

// File: hw/rtl/dsa_fifo.sv
// ----------------------------------------------------------------------------
// Descriptor slot allocator queue
// Small register queue with full and empty flags.
// ----------------------------------------------------------------------------
module dsa_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic             do_push;
   logic             do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = entries_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

// File: hw/rtl/dsa_front.sv
// ----------------------------------------------------------------------------
// Descriptor slot allocator front end
// Accepts requests, range-checks them and queues a classified command.
// ----------------------------------------------------------------------------
module dsa_front import dsa_pkg::*; #(
   parameter int MAX_SLOTS = 1024
) (
   input  logic                           clearing,
   input  logic [$clog2(MAX_SLOTS+1)-1:0] usable,
   input  logic                           req_push,
   output logic                           req_full,
   input  req_type                        req_data,
   output logic                           cmd_push,
   output cmd_type                        cmd_data,
   input  logic                           cmd_full
);

   localparam int CW = $clog2(MAX_SLOTS + 1);
   localparam int TW = (CW > SLOT_W) ? CW : SLOT_W;

   logic [TW-1:0] usable_x;
   logic [TW-1:0] base_x;
   logic [TW-1:0] slot_x;

   // hold requests off while the map is being cleared
   assign req_full = cmd_full || clearing;
   assign cmd_push = req_push && !req_full;

   assign usable_x = TW'(usable);
   assign base_x   = TW'(req_data.search_base);
   assign slot_x   = TW'(req_data.slot_index);

   always_comb begin
      cmd_data        = '0;
      cmd_data.op     = OP_REJECT;
      cmd_data.status = ST_OUT_OF_RANGE;
      cmd_data.target = req_data.slot_index;
      unique case (req_data.func)
         FUNC_AUTO: begin
            cmd_data.target = req_data.search_base;
            if (base_x >= usable_x) begin
               cmd_data.status = ST_NO_FREE;
            end else begin
               cmd_data.op     = OP_AUTO;
               cmd_data.status = ST_OK;
            end
         end
         FUNC_FIXED: begin
            if (slot_x < usable_x) begin
               cmd_data.op     = OP_FIXED;
               cmd_data.status = ST_OK;
            end
         end
         FUNC_FREE: begin
            if (slot_x < usable_x) begin
               cmd_data.op     = OP_FREE;
               cmd_data.status = ST_OK;
            end
         end
         default: begin
            cmd_data.op = OP_REJECT;
         end
      endcase
   end

endmodule

// File: hw/rtl/dsa_back.sv
// ----------------------------------------------------------------------------
// Descriptor slot allocator back end
// Owns the free bitmap memory, walks it word by word and builds handles.
// ----------------------------------------------------------------------------
module dsa_back import dsa_pkg::*; #(
   parameter int MAX_SLOTS     = 1024,
   parameter int MAP_WORD_BITS = 64
) (
   input  logic                           clock,
   input  logic                           reset,
   input  cfg_type                        cfg,
   input  logic [$clog2(MAX_SLOTS+1)-1:0] usable,
   input  cmd_type                        cmd_data,
   input  logic                           cmd_empty,
   output logic                           cmd_pop,
   output logic                           rsp_push,
   output rsp_type                        rsp_data,
   input  logic                           rsp_full,
   output back_stat_type                  stat
);

   localparam int SW    = $clog2(MAX_SLOTS);
   localparam int BW    = SW + 1;
   localparam int WB    = MAP_WORD_BITS;
   localparam int OW    = $clog2(WB);
   localparam int DEPTH = (MAX_SLOTS + WB - 1) / WB;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int PW    = SW + HSIZE_W;

   back_state_type    state_ff, state_in;
   logic [AW-1:0]     clr_ff, clr_in;
   op_type            op_ff, op_in;
   logic [SLOT_W-1:0] rem_ff, rem_in;
   logic [AW-1:0]     word_ff, word_in;
   logic [SW-1:0]     wbase_ff, wbase_in;
   logic [SW-1:0]     slot_ff, slot_in;
   logic [PW-1:0]     prod_ff, prod_in;
   rsp_type           res_ff, res_in;

   logic [WB-1:0]     map_mem [DEPTH];
   logic [WB-1:0]     rd_ff;
   logic              mem_we;
   logic [AW-1:0]     mem_waddr;
   logic [WB-1:0]     mem_wdata;

   logic [OW-1:0]     rem_off;
   logic [BW-1:0]     usable_b;
   logic [BW-1:0]     wbase_next;
   logic [BW-1:0]     lim;
   logic [WB-1:0]     mask;
   logic [WB-1:0]     hit;
   logic [WB-1:0]     low1;
   logic [OW-1:0]     enc;
   logic [WB-1:0]     bit_sel;
   logic [SW-1:0]     slot_fix;
   logic [SW-1:0]     slot_auto;

   assign rem_off    = rem_ff[OW-1:0];
   assign usable_b   = BW'(usable);
   assign wbase_next = BW'(wbase_ff) + BW'(WB);
   assign lim        = usable_b - BW'(wbase_ff);
   assign bit_sel    = WB'(1) << rem_off;
   assign slot_fix   = wbase_ff + SW'(rem_off);
   assign slot_auto  = wbase_ff + SW'(enc);

   // eligible bits of the current word: at or above the base, below the usable count
   always_comb begin
      for (int b = 0; b < WB; b++) begin
         mask[b] = (SLOT_W'(b) >= rem_ff) && (BW'(b) < lim);
      end
   end

   assign hit  = rd_ff & mask;
   assign low1 = hit & (~hit + WB'(1));

   always_comb begin
      enc = '0;
      for (int b = 0; b < WB; b++) begin
         if (low1[b]) begin
            enc = enc | OW'(b);
         end
      end
   end

   always_comb begin
      state_in  = state_ff;
      clr_in    = clr_ff;
      op_in     = op_ff;
      rem_in    = rem_ff;
      word_in   = word_ff;
      wbase_in  = wbase_ff;
      slot_in   = slot_ff;
      prod_in   = prod_ff;
      res_in    = res_ff;
      mem_we    = 1'b0;
      mem_waddr = word_ff;
      mem_wdata = rd_ff;
      cmd_pop   = 1'b0;
      rsp_push  = 1'b0;
      unique case (state_ff)
         BK_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = '1;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == AW'(DEPTH - 1)) begin
               state_in = BK_IDLE;
            end
         end
         BK_IDLE: begin
            if (!cmd_empty) begin
               cmd_pop       = 1'b1;
               op_in         = cmd_data.op;
               rem_in        = cmd_data.target;
               word_in       = '0;
               wbase_in      = '0;
               res_in        = '0;
               res_in.status = cmd_data.status;
               state_in      = (cmd_data.op == OP_REJECT) ? BK_OUT : BK_WALK;
            end
         end
         BK_WALK: begin
            // advance to the word that holds the target slot
            if (rem_ff >= SLOT_W'(WB)) begin
               rem_in   = rem_ff - SLOT_W'(WB);
               word_in  = word_ff + 1'b1;
               wbase_in = wbase_next[SW-1:0];
            end else begin
               state_in = BK_READ;
            end
         end
         BK_READ: begin
            state_in = BK_CHECK;
         end
         BK_CHECK: begin
            unique case (op_ff)
               OP_FREE: begin
                  mem_we              = 1'b1;
                  mem_wdata           = rd_ff | bit_sel;
                  res_in.status       = ST_OK;
                  res_in.granted_slot = SLOT_W'(slot_fix);
                  state_in            = BK_OUT;
               end
               OP_FIXED: begin
                  if (rd_ff[rem_off]) begin
                     mem_we    = 1'b1;
                     mem_wdata = rd_ff & ~bit_sel;
                     slot_in   = slot_fix;
                     state_in  = BK_MUL;
                  end else begin
                     res_in.status = ST_TAKEN;
                     state_in      = BK_OUT;
                  end
               end
               OP_AUTO: begin
                  if (|hit) begin
                     mem_we    = 1'b1;
                     mem_wdata = rd_ff & ~low1;
                     slot_in   = slot_auto;
                     state_in  = BK_MUL;
                  end else if (wbase_next >= usable_b) begin
                     res_in.status = ST_NO_FREE;
                     state_in      = BK_OUT;
                  end else begin
                     // later words are searched from their first bit
                     word_in  = word_ff + 1'b1;
                     wbase_in = wbase_next[SW-1:0];
                     rem_in   = '0;
                     state_in = BK_READ;
                  end
               end
               default: begin
                  state_in = BK_OUT;
               end
            endcase
         end
         BK_MUL: begin
            prod_in  = PW'(slot_ff) * PW'(cfg.handle_size);
            state_in = BK_ADD;
         end
         BK_ADD: begin
            res_in.status       = ST_OK;
            res_in.granted_slot = SLOT_W'(slot_ff);
            res_in.cpu_handle   = cfg.cpu_heap_start + ADDR_W'(prod_ff);
            if (cfg.shader_heap_present) begin
               res_in.shader_cpu_handle = cfg.shader_cpu_heap_start + ADDR_W'(prod_ff);
               res_in.shader_gpu_handle = cfg.shader_gpu_heap_start + ADDR_W'(prod_ff);
            end
            state_in = BK_OUT;
         end
         BK_OUT: begin
            if (!rsp_full) begin
               rsp_push = 1'b1;
               state_in = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff    <= op_in;
      rem_ff   <= rem_in;
      word_ff  <= word_in;
      wbase_ff <= wbase_in;
      slot_ff  <= slot_in;
      prod_ff  <= prod_in;
      res_ff   <= res_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         map_mem[mem_waddr] <= mem_wdata;
      end
      rd_ff <= map_mem[word_ff];
   end

   assign rsp_data      = res_ff;
   assign stat.clearing = (state_ff == BK_CLEAR);
   assign stat.idle     = (state_ff == BK_IDLE);

endmodule

// File: hw/rtl/descriptor_slot_allocator_core.sv
// ----------------------------------------------------------------------------
// Descriptor slot allocator core
// Path: a reject goes straight to the response; a free walks to its word, reads
//   and checks it; allocations also build handles, and an automatic search reads each extra word.
// Throughput: one request at a time in the bitmap walker (one walker serves the map).
// Reset: synchronous; a clearing pass over the MAX_SLOTS/MAP_WORD_BITS map words (16 by
//   default) fills the map with free marks while req_full is held high.
// ----------------------------------------------------------------------------
`include "descriptor_slot_allocator_core_assert.svh"

module descriptor_slot_allocator_core import dsa_pkg::*; #(
   parameter int MAX_SLOTS     = 1024,
   parameter int MAP_WORD_BITS = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  logic                   req_push,
   output logic                   req_full,
   input  req_type                req_data,
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output rsp_type                rsp_data
);

   localparam int CW = $clog2(MAX_SLOTS + 1);
   localparam int XW = (CW > COUNT_W) ? CW : COUNT_W;

   logic [COUNT_W-1:0] slot_count_ff;
   cfg_type            cfg_ff;
   logic [XW-1:0]      count_x;
   logic [CW-1:0]      usable;

   cmd_type            cmd_in_data;
   cmd_type            cmd_out_data;
   logic               cmd_push;
   logic               cmd_full;
   logic               cmd_pop;
   logic               cmd_empty;
   logic               rsp_push;
   logic               rsp_q_full;
   rsp_type            rsp_in_data;
   back_stat_type      back_stat;

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_count_ff                <= SLOT_COUNT_RESET;
         cfg_ff.handle_size           <= HANDLE_SIZE_RESET;
         cfg_ff.cpu_heap_start        <= '0;
         cfg_ff.shader_cpu_heap_start <= '0;
         cfg_ff.shader_gpu_heap_start <= '0;
         cfg_ff.shader_heap_present   <= 1'b0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_SLOT_COUNT:     slot_count_ff <= csr_wdata[COUNT_W-1:0];
            CSR_HANDLE_SIZE:    cfg_ff.handle_size <= csr_wdata[HSIZE_W-1:0];
            CSR_CPU_START:      cfg_ff.cpu_heap_start <= csr_wdata[ADDR_W-1:0];
            CSR_SHADER_CPU:     cfg_ff.shader_cpu_heap_start <= csr_wdata[ADDR_W-1:0];
            CSR_SHADER_GPU:     cfg_ff.shader_gpu_heap_start <= csr_wdata[ADDR_W-1:0];
            CSR_SHADER_PRESENT: cfg_ff.shader_heap_present <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   // clamp the programmed count to the map size
   assign count_x = XW'(slot_count_ff);
   assign usable  = (count_x < XW'(MAX_SLOTS)) ? CW'(count_x) : CW'(MAX_SLOTS);

   dsa_front #(
      .MAX_SLOTS (MAX_SLOTS)
   ) u_front (
      .clearing (back_stat.clearing),
      .usable   (usable),
      .req_push (req_push),
      .req_full (req_full),
      .req_data (req_data),
      .cmd_push (cmd_push),
      .cmd_data (cmd_in_data),
      .cmd_full (cmd_full)
   );

   dsa_fifo #(
      .WIDTH ($bits(cmd_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_cmd_q (
      .clock (clock),
      .reset (reset),
      .push  (cmd_push),
      .wdata (cmd_in_data),
      .full  (cmd_full),
      .pop   (cmd_pop),
      .rdata (cmd_out_data),
      .empty (cmd_empty)
   );

   dsa_back #(
      .MAX_SLOTS     (MAX_SLOTS),
      .MAP_WORD_BITS (MAP_WORD_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .usable    (usable),
      .cmd_data  (cmd_out_data),
      .cmd_empty (cmd_empty),
      .cmd_pop   (cmd_pop),
      .rsp_push  (rsp_push),
      .rsp_data  (rsp_in_data),
      .rsp_full  (rsp_q_full),
      .stat      (back_stat)
   );

   dsa_fifo #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_rsp_q (
      .clock (clock),
      .reset (reset),
      .push  (rsp_push),
      .wdata (rsp_in_data),
      .full  (rsp_q_full),
      .pop   (rsp_pop),
      .rdata (rsp_data),
      .empty (rsp_empty)
   );

   `DSA_ASSERT_IMP(a_clear_after_reset, clock, reset, $fell(reset), req_full)
   `DSA_ASSERT_NXT(a_pop_starts_work, clock, reset, cmd_pop, !back_stat.idle)
   `DSA_ASSERT_IMP(a_push_has_room, clock, reset, rsp_push, !rsp_q_full)
   `DSA_ASSERT_NXT(a_push_shows_rsp, clock, reset, rsp_push, !rsp_empty)

endmodule

// File: dv/testbench.sv
// ----------------------------------------------------------------------------
// Descriptor slot allocator testbench
// Drives allocate, fixed-claim and free requests through the queue ports with
// random gaps and response stalls, predicts each response from a local copy of
// the free map and the heap registers, and compares every field in order.
// ----------------------------------------------------------------------------
module testbench;
   import dsa_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int SLOT_CAPACITY = 1024;
   localparam int CYCLE_LIMIT   = 1000000;
   localparam int PHASE_ITEMS   = 193;
   localparam int PRINT_LIMIT   = 50;

   localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
   localparam logic [ADDR_W-1:0] ADDR_ONES   = {ADDR_W{1'b1}};

   logic                   clock;
   logic                   reset;
   logic                   csr_wr_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;
   logic                   req_push;
   logic                   req_full;
   req_type                req_data;
   logic                   rsp_empty;
   logic                   rsp_pop = 1'b0;
   rsp_type                rsp_data;

   // local copy of the allocator state
   bit                 slot_free [SLOT_CAPACITY];
   logic [COUNT_W-1:0] cfg_slot_count;
   logic [HSIZE_W-1:0] cfg_handle_size;
   logic [ADDR_W-1:0]  cfg_cpu_start;
   logic [ADDR_W-1:0]  cfg_shader_cpu_start;
   logic [ADDR_W-1:0]  cfg_shader_gpu_start;
   logic               cfg_shader_present;

   rsp_type expected_grants [$];
   int      mismatch_count = 0;
   int      response_count = 0;
   int      cycle_count = 0;
   bit      calm_traffic = 1'b0;

   descriptor_slot_allocator_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   function automatic int unsigned usable_slots();
      return (cfg_slot_count < SLOT_CAPACITY) ? int'(cfg_slot_count) : SLOT_CAPACITY;
   endfunction

   function automatic logic [ADDR_W-1:0] heap_address(logic [ADDR_W-1:0] start,
                                                       logic [SLOT_W-1:0] slot);
      return start + ADDR_W'(slot) * ADDR_W'(cfg_handle_size);
   endfunction

   // work out the response and update the free map for one accepted request
   function automatic rsp_type predict_allocation(req_type r);
      rsp_type           res;
      int unsigned       usable;
      int unsigned       s;
      logic              grant;
      logic [SLOT_W-1:0] pick;
      res    = '0;
      grant  = 1'b0;
      pick   = '0;
      usable = usable_slots();
      case (r.func)
         FUNC_AUTO: begin
            res.status = ST_NO_FREE;
            for (s = r.search_base; s < usable; s++) begin
               if (slot_free[s]) begin
                  res.status = ST_OK;
                  pick       = s[SLOT_W-1:0];
                  grant      = 1'b1;
                  break;
               end
            end
         end
         FUNC_FIXED: begin
            if (r.slot_index >= usable) res.status = ST_OUT_OF_RANGE;
            else if (!slot_free[r.slot_index]) res.status = ST_TAKEN;
            else begin
               pick  = r.slot_index;
               grant = 1'b1;
            end
         end
         FUNC_FREE: begin
            if (r.slot_index >= usable) res.status = ST_OUT_OF_RANGE;
            else begin
               slot_free[r.slot_index] = 1'b1;
               res.granted_slot        = r.slot_index;
            end
         end
         default: res.status = ST_OUT_OF_RANGE;
      endcase
      if (grant) begin
         slot_free[pick]  = 1'b0;
         res.granted_slot = pick;
         res.cpu_handle   = heap_address(cfg_cpu_start, pick);
         if (cfg_shader_present) begin
            res.shader_cpu_handle = heap_address(cfg_shader_cpu_start, pick);
            res.shader_gpu_handle = heap_address(cfg_shader_gpu_start, pick);
         end
      end
      return res;
   endfunction

   function automatic bit idle_roll();
      return !calm_traffic && ($urandom_range(99) < 32);
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      if (mismatch_count < PRINT_LIMIT)
         $display("mismatch on response %0d, %s: got 0x%0h, expected 0x%0h",
                  response_count, what, got, want);
      mismatch_count++;
   endtask

   // response stalls
   always @(posedge clock) begin
      if (reset) rsp_pop <= 1'b0;
      else rsp_pop <= !idle_roll();
   end

   always @(posedge clock) begin : check_responses
      rsp_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (expected_grants.size() == 0) begin
            report_mismatch("response with no request outstanding", rsp_data.status, 0);
         end else begin
            want = expected_grants.pop_front();
            if (rsp_data.status !== want.status)
               report_mismatch("status", rsp_data.status, want.status);
            if (rsp_data.granted_slot !== want.granted_slot)
               report_mismatch("granted_slot", rsp_data.granted_slot, want.granted_slot);
            if (rsp_data.cpu_handle !== want.cpu_handle)
               report_mismatch("cpu_handle", rsp_data.cpu_handle, want.cpu_handle);
            if (rsp_data.shader_cpu_handle !== want.shader_cpu_handle)
               report_mismatch("shader_cpu_handle", rsp_data.shader_cpu_handle,
                               want.shader_cpu_handle);
            if (rsp_data.shader_gpu_handle !== want.shader_gpu_handle)
               report_mismatch("shader_gpu_handle", rsp_data.shader_gpu_handle,
                               want.shader_gpu_handle);
         end
         response_count++;
      end
   end

   // push is left high after acceptance so back-to-back requests stay gapless
   task automatic send_request(req_type r);
      while (idle_roll()) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (req_full) @(posedge clock);
      expected_grants.push_back(predict_allocation(r));
   endtask

   task automatic send_fields(logic [FUNC_W-1:0] func, int unsigned base, int unsigned slot);
      req_type r;
      r.func        = func;
      r.search_base = SLOT_W'(base);
      r.slot_index  = SLOT_W'(slot);
      send_request(r);
   endtask

   task automatic drain_results();
      req_push <= 1'b0;
      while (expected_grants.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   task automatic configure(logic [COUNT_W-1:0] count, logic [HSIZE_W-1:0] hsize,
                            logic [ADDR_W-1:0] cpu, logic [ADDR_W-1:0] scpu,
                            logic [ADDR_W-1:0] sgpu, logic present);
      write_csr(CSR_SLOT_COUNT, CSR_DATA_W'(count));
      write_csr(CSR_HANDLE_SIZE, CSR_DATA_W'(hsize));
      write_csr(CSR_CPU_START, cpu);
      write_csr(CSR_SHADER_CPU, scpu);
      write_csr(CSR_SHADER_GPU, sgpu);
      write_csr(CSR_SHADER_PRESENT, CSR_DATA_W'(present));
      csr_wr_en <= 1'b0;
      cfg_slot_count       = count;
      cfg_handle_size      = hsize;
      cfg_cpu_start        = cpu;
      cfg_shader_cpu_start = scpu;
      cfg_shader_gpu_start = sgpu;
      cfg_shader_present   = present;
   endtask

   function automatic logic [ADDR_W-1:0] random_address();
      return ADDR_W'({$urandom(), $urandom()});
   endfunction

   function automatic int pick_taken_slot(int unsigned usable);
      int s;
      for (int k = 0; k < 16; k++) begin
         s = $urandom_range(usable - 1);
         if (!slot_free[s]) return s;
      end
      return -1;
   endfunction

   // mostly in-range requests; a share lands outside the usable range
   function automatic req_type random_request(int unsigned usable);
      req_type     r;
      int unsigned roll;
      int          held;
      r.search_base = SLOT_W'($urandom());
      r.slot_index  = SLOT_W'($urandom());
      roll = $urandom_range(99);
      if (roll < 40) begin
         r.func = FUNC_AUTO;
         roll   = $urandom_range(99);
         if (roll < 70) r.search_base = SLOT_W'($urandom_range(usable - 1));
         else if (roll < 85)
            r.search_base = SLOT_W'(usable - 1 - $urandom_range(usable > 4 ? 3 : usable - 1));
      end else if (roll < 62) begin
         r.func = FUNC_FIXED;
         if ($urandom_range(99) < 75) r.slot_index = SLOT_W'($urandom_range(usable - 1));
      end else if (roll < 95) begin
         r.func = FUNC_FREE;
         roll   = $urandom_range(99);
         held   = pick_taken_slot(usable);
         if (roll < 70 && held >= 0) r.slot_index = SLOT_W'(held);
         else if (roll < 90) r.slot_index = SLOT_W'($urandom_range(usable - 1));
      end else begin
         r.func = FUNC_UNUSED;
      end
      return r;
   endfunction

   task automatic test_reset_defaults();
      send_fields(FUNC_AUTO, 0, 0);
      send_fields(FUNC_AUTO, 1023, 0);
      send_fields(FUNC_FIXED, 0, 0);
      send_fields(FUNC_FIXED, 0, 1023);
      send_fields(FUNC_FIXED, 0, 512);
      send_fields(FUNC_FREE, 0, 512);
      // release a slot that is already free
      send_fields(FUNC_FREE, 0, 512);
      send_fields(FUNC_UNUSED, 1023, 1023);
      send_fields(FUNC_AUTO, 0, 1023);
      drain_results();
   endtask

   task automatic test_edge_cases();
      configure(11'd1, 9'd256, ADDR_ONES, ADDR_ONES, 48'h8000_0000_0000, 1'b1);
      send_fields(FUNC_FREE, 1023, 0);
      send_fields(FUNC_AUTO, 0, 0);
      send_fields(FUNC_AUTO, 0, 0);
      // base at the usable limit
      send_fields(FUNC_AUTO, 1, 0);
      send_fields(FUNC_FIXED, 0, 1);
      send_fields(FUNC_FREE, 0, 1023);
      send_fields(FUNC_FIXED, 0, 0);
      drain_results();
   endtask

   task automatic test_address_wrap();
      configure(11'd1024, 9'd256, ADDR_ONES, ADDR_ONES, 48'h8000_0000_0000, 1'b1);
      send_fields(FUNC_FREE, 0, 1023);
      send_fields(FUNC_FIXED, 0, 1023);
      send_fields(FUNC_AUTO, 1000, 0);
      send_fields(FUNC_AUTO, 1023, 0);
      drain_results();
   endtask

   task automatic test_random_traffic();
      logic [COUNT_W-1:0] count;
      logic [HSIZE_W-1:0] hsize;
      logic [ADDR_W-1:0]  cpu;
      logic [ADDR_W-1:0]  scpu;
      logic [ADDR_W-1:0]  sgpu;
      logic               present;
      int unsigned        usable;
      for (int phase = 0; phase < 10; phase++) begin
         count   = COUNT_W'($urandom_range(1, SLOT_CAPACITY));
         hsize   = HSIZE_W'($urandom_range(1, 256));
         cpu     = random_address();
         scpu    = random_address();
         sgpu    = random_address();
         present = 1'($urandom());
         case (phase)
            0: begin
               count   = 11'd64;
               hsize   = 9'd1;
               cpu     = '0;
               scpu    = '0;
               sgpu    = '0;
               present = 1'b0;
            end
            1: begin
               count   = 11'd1024;
               hsize   = 9'd256;
               cpu     = ADDR_ONES;
               scpu    = ADDR_ONES;
               sgpu    = ADDR_ONES;
               present = 1'b1;
            end
            2: count = 11'd1;
            3: count = 11'd100;
            4: count = 11'd1024;
            5: begin
               count = 11'd65;
               hsize = 9'd256;
            end
            6: begin
               count = 11'd200;
               hsize = 9'd1;
            end
            7: count = 11'd1024;
            default: ;
         endcase
         configure(count, hsize, cpu, scpu, sgpu, present);
         usable       = usable_slots();
         // hold both sides busy for one whole phase
         calm_traffic = (phase == 4);
         for (int n = 0; n < PHASE_ITEMS; n++) send_request(random_request(usable));
         drain_results();
         calm_traffic = 1'b0;
      end
   endtask

   initial begin
      reset     <= 1'b1;
      req_push  <= 1'b0;
      req_data  <= '0;
      csr_wr_en <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      foreach (slot_free[i]) slot_free[i] = 1'b1;
      cfg_slot_count       = SLOT_COUNT_RESET;
      cfg_handle_size      = HANDLE_SIZE_RESET;
      cfg_cpu_start        = '0;
      cfg_shader_cpu_start = '0;
      cfg_shader_gpu_start = '0;
      cfg_shader_present   = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_edge_cases();
      test_address_wrap();
      test_random_traffic();

      repeat (60) @(posedge clock);
      if (mismatch_count == 0 && expected_grants.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
